@@ design/sprk_pkg.sv @@
// Shared constants, types and register codes of the sphere-projected kick block.
package sprk_pkg;

	// Width of a Q16.16 field and of the magnitudes handled by the rescale unit.
	localparam int unsigned MAG_W = 32;
	// Width of a shifted point or kick component, signed.
	localparam int unsigned VEC_W = MAG_W + 2;
	// Width of the cutoff register.
	localparam int unsigned CUT_W = MAG_W - 1;
	// One root bit per square root stage and one quotient bit per divider stage.
	localparam int unsigned SQRT_STEPS = MAG_W;
	localparam int unsigned DIV_STEPS  = MAG_W;
	// A component magnitude needs at most this many halvings to reach the limit.
	localparam int unsigned SHIFT_STEPS = VEC_W - MAG_W;

	localparam logic [VEC_W-1:0] MAG_LIMIT = VEC_W'(64'h8000_0000);
	localparam logic [VEC_W-1:0] SAT_MAX   = VEC_W'(64'h7FFF_FFFF);
	localparam logic [VEC_W-1:0] SAT_MIN   = VEC_W'(64'hFFFF_FFFF_8000_0000);

	// Fixed-point 1.0 and its square.
	localparam logic [CUT_W-1:0]   FIX_ONE    = CUT_W'(65536);
	localparam logic [2*MAG_W-1:0] FIX_ONE_SQ = 64'h0000_0001_0000_0000;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRUNCATE_ENABLE = 2'd1;

	// Sideband that travels with a vector through the rescale unit.
	typedef struct packed {
		logic [2:0][VEC_W-1:0] vec;
		logic                  last;
		logic                  degen;
		logic                  clip;
	} side_t;

endpackage

@@ design/sprk_if.sv @@
// Channel interfaces: node input, kick output and configuration writes.
interface sprk_node_if;
	logic        valid;
	logic        ready;
	logic [31:0] point_x;
	logic [31:0] point_y;
	logic [31:0] point_z;
	logic [31:0] noise_x;
	logic [31:0] noise_y;
	logic [31:0] noise_z;
	logic        last_node;

	modport source (output valid, point_x, point_y, point_z, noise_x, noise_y, noise_z,
		last_node, input ready);
	modport sink (input valid, point_x, point_y, point_z, noise_x, noise_y, noise_z,
		last_node, output ready);
endinterface

interface sprk_kick_if;
	logic        valid;
	logic        ready;
	logic [31:0] kick_x;
	logic [31:0] kick_y;
	logic [31:0] kick_z;
	logic        was_clipped;
	logic        degenerate;
	logic        sweep_end;

	modport source (output valid, kick_x, kick_y, kick_z, was_clipped, degenerate, sweep_end,
		input ready);
	modport sink (input valid, kick_x, kick_y, kick_z, was_clipped, degenerate, sweep_end,
		output ready);
endinterface

interface sprk_cfg_if import sprk_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/sprk_rescale.sv @@
// Pipelined rescale of a 3D vector to a length given by its square, 70 stages.
module sprk_rescale import sprk_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2:0][VEC_W-1:0] in_vec,
	input  logic [2*MAG_W-1:0]    in_len_sq,
	input  side_t                 in_side,
	output logic                  out_valid,
	output logic [2:0][VEC_W-1:0] out_vec,
	output logic                  out_nz,
	output side_t                 out_side
);

	typedef struct packed {
		logic [2:0][MAG_W-1:0] m;
		logic [2:0]            neg;
		side_t                 side;
	} carry_t;

	typedef struct packed {
		logic [2*MAG_W-1:0] rad;
		logic [MAG_W+1:0]   rem;
		logic [MAG_W-1:0]   root;
	} sqrt_t;

	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [MAG_W-1:0] low;
		logic [MAG_W-1:0] quo;
	} div_t;

	// One root bit: bring down two radicand bits and try to subtract 4r+1.
	function automatic sqrt_t sqrt_step(input sqrt_t a);
		logic [MAG_W+3:0] cat;
		logic [MAG_W+3:0] trial;
		sqrt_t            r;
		cat   = {a.rem, a.rad[2*MAG_W-1 -: 2]};
		trial = {2'b00, a.root, 2'b01};
		r.rad = {a.rad[2*MAG_W-3:0], 2'b00};
		if (cat >= trial) begin
			r.rem  = (MAG_W+2)'(cat - trial);
			r.root = {a.root[MAG_W-2:0], 1'b1};
		end else begin
			r.rem  = (MAG_W+2)'(cat);
			r.root = {a.root[MAG_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// One quotient bit of a restoring division.
	function automatic div_t div_step(input div_t a, input logic [MAG_W-1:0] n);
		logic [MAG_W:0] cat;
		div_t           r;
		cat   = {a.rem, a.low[MAG_W-1]};
		r.low = {a.low[MAG_W-2:0], 1'b0};
		if (cat >= {1'b0, n}) begin
			r.rem = MAG_W'(cat - {1'b0, n});
			r.quo = {a.quo[MAG_W-2:0], 1'b1};
		end else begin
			r.rem = cat[MAG_W-1:0];
			r.quo = {a.quo[MAG_W-2:0], 1'b0};
		end
		return r;
	endfunction

	logic [2:0][VEC_W-1:0]   mag_c;
	logic [2:0][VEC_W-1:0]   shf_c;
	logic [2:0]              neg_c;
	logic                    v_s1, v_s2, v_s4;
	carry_t                  c_s1, c_s2, c_s4;
	logic [2*MAG_W-1:0]      lsq_s1, lsq_s2;
	logic [2:0][2*MAG_W-1:0] sq_s2;
	logic [2:0][2*MAG_W-1:0] prod_s4;
	logic [MAG_W-1:0]        n_s4;
	logic [2:0][2*MAG_W-1:0] dd_c;

	logic   sv_s [SQRT_STEPS+1];
	sqrt_t  sn_s [SQRT_STEPS+1];
	sqrt_t  sl_s [SQRT_STEPS+1];
	carry_t sc_s [SQRT_STEPS+1];

	logic             dv_s [DIV_STEPS+1];
	div_t [2:0]       dl_s [DIV_STEPS+1];
	logic [MAG_W-1:0] dn_s [DIV_STEPS+1];
	logic [2:0]       dg_s [DIV_STEPS+1];
	side_t            ds_s [DIV_STEPS+1];

	logic                  v_s6;
	logic [2:0][VEC_W-1:0] vec_s6;
	logic                  nz_s6;
	side_t                 side_s6;

	// Magnitudes, halved together until every one is within the limit.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = in_vec[i][VEC_W-1];
			mag_c[i] = neg_c[i] ? -in_vec[i] : in_vec[i];
		end
		shf_c = mag_c;
		for (int j = 0; j < SHIFT_STEPS; j++) begin
			if (shf_c[0] > MAG_LIMIT || shf_c[1] > MAG_LIMIT || shf_c[2] > MAG_LIMIT) begin
				for (int i = 0; i < 3; i++) begin
					shf_c[i] = shf_c[i] >> 1;
				end
			end
		end
	end

	// Dividend with half the divisor added, so the quotient rounds to nearest.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dd_c[i] = prod_s4[i] + {{(MAG_W+1){1'b0}}, n_s4[MAG_W-1:1]};
		end
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			sv_s[0]  <= 1'b0;
			v_s4     <= 1'b0;
			dv_s[0]  <= 1'b0;
			v_s6     <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			sv_s[0]  <= v_s2;
			v_s4     <= sv_s[SQRT_STEPS];
			dv_s[0]  <= v_s4;
			v_s6     <= dv_s[DIV_STEPS];
		end
	end

	// Payload of the fixed stages: shift, square, sum, scale and sign.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s1.m[i]  <= shf_c[i][MAG_W-1:0];
				sq_s2[i]   <= c_s1.m[i] * c_s1.m[i];
				prod_s4[i] <= sc_s[SQRT_STEPS].m[i] * sl_s[SQRT_STEPS].root;
				dl_s[0][i] <= '{rem: dd_c[i][2*MAG_W-1:MAG_W], low: dd_c[i][MAG_W-1:0],
					quo: '0};
				vec_s6[i]  <= dg_s[DIV_STEPS][i] ? -{2'b00, dl_s[DIV_STEPS][i].quo}
					: {2'b00, dl_s[DIV_STEPS][i].quo};
			end
			c_s1.neg  <= neg_c;
			c_s1.side <= in_side;
			lsq_s1    <= in_len_sq;
			c_s2      <= c_s1;
			lsq_s2    <= lsq_s1;
			sn_s[0]   <= '{rad: sq_s2[0] + sq_s2[1] + sq_s2[2], rem: '0, root: '0};
			sl_s[0]   <= '{rad: lsq_s2, rem: '0, root: '0};
			sc_s[0]   <= c_s2;
			c_s4      <= sc_s[SQRT_STEPS];
			n_s4      <= sn_s[SQRT_STEPS].root;
			dn_s[0]   <= n_s4;
			dg_s[0]   <= c_s4.neg;
			ds_s[0]   <= c_s4.side;
			nz_s6     <= dn_s[DIV_STEPS] != '0;
			side_s6   <= ds_s[DIV_STEPS];
		end
	end

	// Square root stages: vector norm and target length side by side.
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[j+1] <= 1'b0;
			end else if (en) begin
				sv_s[j+1] <= sv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sn_s[j+1] <= sqrt_step(sn_s[j]);
				sl_s[j+1] <= sqrt_step(sl_s[j]);
				sc_s[j+1] <= sc_s[j];
			end
		end
	end

	// Divider stages, three lanes sharing the norm as divisor.
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_s[j+1] <= dv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dl_s[j+1][i] <= div_step(dl_s[j][i], dn_s[j]);
				end
				dn_s[j+1] <= dn_s[j];
				dg_s[j+1] <= dg_s[j];
				ds_s[j+1] <= ds_s[j];
			end
		end
	end

	assign out_valid = v_s6;
	assign out_vec   = vec_s6;
	assign out_nz    = nz_s6;
	assign out_side  = side_s6;

endmodule

@@ design/sphere_projected_random_kick_core.sv @@
// Top level of the sphere-projected random kick pipeline.
// A result passes the front end, two rescale units, the cutoff test and the output register.
// Throughput: one node per unstalled cycle; 32-stage roots and dividers are fully pipelined.
// A stall at the output holds every stage; nothing is lost or repeated.
// Reset clears all valid bits and loads cutoff_length = 1.0 and truncate_enable = 1.
module sphere_projected_random_kick_core import sprk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sprk_node_if.sink   node_in,
	sprk_kick_if.source kick_out,
	sprk_cfg_if.sink    cfg
);

	// Saturate a 34-bit signed component to the 32-bit range.
	function automatic logic [MAG_W-1:0] sat32(input logic [VEC_W-1:0] v);
		if ($signed(v) > $signed(SAT_MAX)) begin
			return SAT_MAX[MAG_W-1:0];
		end else if ($signed(v) < $signed(SAT_MIN)) begin
			return SAT_MIN[MAG_W-1:0];
		end
		return v[MAG_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] mag32(input logic [MAG_W-1:0] v);
		return v[MAG_W-1] ? -v : v;
	endfunction

	logic                    en;
	logic [CUT_W-1:0]        cutoff_q;
	logic                    trunc_q;
	logic [2*MAG_W-1:0]      cutoff_sq_q;

	logic [2:0][MAG_W-1:0]   pin_c, rin_c;
	logic [2:0][MAG_W-1:0]   p_s1, p_s2, p_s3;
	logic [2:0][MAG_W-1:0]   pm_s1;
	logic [2:0][VEC_W-1:0]   s_s1, s_s2, s_s3;
	logic [2:0][2*MAG_W-1:0] psq_s2;
	logic [2*MAG_W-1:0]      psum_s3;
	logic                    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic                    last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;
	side_t                   side1_c, side2_c;

	logic                    r1_valid, r1_nz, r2_valid, r2_nz;
	logic [2:0][VEC_W-1:0]   r1_vec, r2_vec;
	side_t                   r1_side, r2_side;

	logic [2:0][VEC_W-1:0]   k_s4, k_s5, k_s6, k_s7, km_c;
	logic [2:0][VEC_W-1:0]   km_s5;
	logic [2:0]              big_s5;
	logic                    big_s6;
	logic [2:0][2*CUT_W-1:0] ksq_s6;
	logic [2*MAG_W-1:0]      ksum_c;
	logic                    degen_s4, degen_s5, degen_s6, degen_s7;
	logic                    clip_s7;
	logic [2:0][VEC_W-1:0]   sel_c;
	logic [2:0][MAG_W-1:0]   kick_s8;
	logic                    clip_s8, degen_s8, last_s8;

	// The whole pipeline advances unless a result waits at the output.
	assign en            = !v_s8 || kick_out.ready;
	assign node_in.ready = en;
	assign cfg.ready     = 1'b1;

	// Configuration registers and the squared cutoff.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q    <= FIX_ONE;
			trunc_q     <= 1'b1;
			cutoff_sq_q <= FIX_ONE_SQ;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_CUTOFF_LENGTH:   cutoff_q <= cfg.data[CUT_W-1:0];
					REG_TRUNCATE_ENABLE: trunc_q  <= cfg.data[0];
					default: ;
				endcase
			end
			cutoff_sq_q <= cutoff_q * cutoff_q;
		end
	end

	// Gather the input transaction into arrays.
	always_comb begin
		pin_c[0] = node_in.point_x;
		pin_c[1] = node_in.point_y;
		pin_c[2] = node_in.point_z;
		rin_c[0] = node_in.noise_x;
		rin_c[1] = node_in.noise_y;
		rin_c[2] = node_in.noise_z;
	end

	// Valid bits of the stages around the two rescale units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= node_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= r1_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= r2_valid;
		end
	end

	// Front end: shifted point s = p + r and the squared radius of p.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i]   <= pin_c[i];
				pm_s1[i]  <= mag32(pin_c[i]);
				s_s1[i]   <= {{2{pin_c[i][MAG_W-1]}}, pin_c[i]}
					+ {{2{rin_c[i][MAG_W-1]}}, rin_c[i]};
				psq_s2[i] <= pm_s1[i] * pm_s1[i];
			end
			last_s1 <= node_in.last_node;
			p_s2    <= p_s1;
			s_s2    <= s_s1;
			last_s2 <= last_s1;
			p_s3    <= p_s2;
			s_s3    <= s_s2;
			last_s3 <= last_s2;
			psum_s3 <= psq_s2[0] + psq_s2[1] + psq_s2[2];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			side1_c.vec[i] = {{2{p_s3[i][MAG_W-1]}}, p_s3[i]};
		end
		side1_c.last  = last_s3;
		side1_c.degen = 1'b0;
		side1_c.clip  = 1'b0;
	end

	// Projection of s onto the sphere of radius |p|.
	sprk_rescale u_project (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_vec    (s_s3),
		.in_len_sq (psum_s3),
		.in_side   (side1_c),
		.out_valid (r1_valid),
		.out_vec   (r1_vec),
		.out_nz    (r1_nz),
		.out_side  (r1_side)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			km_c[i] = k_s4[i][VEC_W-1] ? -k_s4[i] : k_s4[i];
		end
		ksum_c = {2'b00, ksq_s6[0]} + {2'b00, ksq_s6[1]} + {2'b00, ksq_s6[2]};
	end

	// Kick and the exact test of its length against the cutoff.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				k_s4[i]   <= r1_nz ? r1_vec[i] - r1_side.vec[i] : '0;
				km_s5[i]  <= km_c[i];
				big_s5[i] <= km_c[i] > {{(VEC_W-CUT_W){1'b0}}, cutoff_q};
				ksq_s6[i] <= big_s5[i] ? '0 : km_s5[i][CUT_W-1:0] * km_s5[i][CUT_W-1:0];
			end
			degen_s4 <= !r1_nz;
			last_s4  <= r1_side.last;
			k_s5     <= k_s4;
			degen_s5 <= degen_s4;
			last_s5  <= last_s4;
			k_s6     <= k_s5;
			degen_s6 <= degen_s5;
			last_s6  <= last_s5;
			big_s6   <= |big_s5;
			k_s7     <= k_s6;
			degen_s7 <= degen_s6;
			last_s7  <= last_s6;
			clip_s7  <= trunc_q && !degen_s6 && (big_s6 || ksum_c > cutoff_sq_q);
		end
	end

	always_comb begin
		side2_c.vec   = k_s7;
		side2_c.last  = last_s7;
		side2_c.degen = degen_s7;
		side2_c.clip  = clip_s7;
	end

	// Rescale of the kick to the cutoff length; used only when clipped.
	sprk_rescale u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_vec    (k_s7),
		.in_len_sq (cutoff_sq_q),
		.in_side   (side2_c),
		.out_valid (r2_valid),
		.out_vec   (r2_vec),
		.out_nz    (r2_nz),
		.out_side  (r2_side)
	);

	// Output register: choose the clipped or plain kick and saturate.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sel_c[i] = (r2_side.clip && r2_nz) ? r2_vec[i] : r2_side.vec[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				kick_s8[i] <= sat32(sel_c[i]);
			end
			clip_s8  <= r2_side.clip && r2_nz;
			degen_s8 <= r2_side.degen;
			last_s8  <= r2_side.last;
		end
	end

	assign kick_out.valid       = v_s8;
	assign kick_out.kick_x      = kick_s8[0];
	assign kick_out.kick_y      = kick_s8[1];
	assign kick_out.kick_z      = kick_s8[2];
	assign kick_out.was_clipped = clip_s8;
	assign kick_out.degenerate  = degen_s8;
	assign kick_out.sweep_end   = last_s8;

	// A degenerate transaction carries a zero, unclipped kick.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		kick_out.valid && kick_out.degenerate |->
		kick_out.kick_x == '0 && kick_out.kick_y == '0 && kick_out.kick_z == '0 &&
		!kick_out.was_clipped)
		else $error("degenerate kick is not zero");

	// Clipping happens only with truncation enabled.
	a_clip_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		kick_out.valid && kick_out.was_clipped |-> trunc_q)
		else $error("kick clipped with truncation disabled");

	// Every component of a clipped kick lies within the cutoff.
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kick_out.valid && kick_out.was_clipped |->
		mag32(kick_out.kick_x) <= {1'b0, cutoff_q} &&
		mag32(kick_out.kick_y) <= {1'b0, cutoff_q} &&
		mag32(kick_out.kick_z) <= {1'b0, cutoff_q})
		else $error("clipped kick component exceeds cutoff");

endmodule
